// ===== rtl/calendar_clock_with_alarm_core_macros.svh =====
// Assertion helpers for the calendar clock core.
`ifndef CALENDAR_CLOCK_WITH_ALARM_CORE_MACROS_SVH
`define CALENDAR_CLOCK_WITH_ALARM_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CCWA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccwa: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define CCWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccwa: next-cycle check failed");
`else
`define CCWA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CCWA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ccwa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccwa_pkg;

    localparam int SecW   = 6;
    localparam int MinW   = 6;
    localparam int HourW  = 5;
    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 7;
    localparam int TickW  = 8;
    localparam int CfgW   = 8;
    localparam int CfgAdrW = 3;

    localparam int InDataW  = 40;
    localparam int OutDataW = 48;

    localparam logic [SecW-1:0]  LastSecond = 6'd59;
    localparam logic [MinW-1:0]  LastMinute = 6'd59;
    localparam logic [HourW-1:0] LastHour   = 5'd23;
    localparam logic [DayW-1:0]  FirstDay   = 5'd1;
    localparam logic [MonW-1:0]  FirstMonth = 4'd1;
    localparam logic [MonW-1:0]  LastMonth  = 4'd12;
    localparam logic [YearW-1:0] LastYear   = 7'd99;
    localparam logic [TickW-1:0] TpsReset   = 8'd8;

    typedef enum logic {
        ActTick = 1'b0,
        ActLoad = 1'b1
    } t_action;

    typedef enum logic [CfgAdrW-1:0] {
        CfgTicksPerSecond = 3'd0,
        CfgAlarmSecond    = 3'd1,
        CfgAlarmMinute    = 3'd2,
        CfgAlarmHour      = 3'd3,
        CfgAlarmEnable    = 3'd4
    } t_cfg_reg;

    // First field sits in the highest bits.
    typedef struct packed {
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
    } t_load;

    typedef struct packed {
        logic             alarm_match;
        logic [TickW-1:0] subsecond;
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
    } t_result;

    localparam int LoadW   = $bits(t_load);
    localparam int ResultW = $bits(t_result);

    function automatic logic [DayW-1:0] f_month_length(input logic [MonW-1:0] month,
                                                       input logic leap);
        logic [DayW-1:0] len;
        unique case (month)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_clock_with_alarm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Real-time clock and calendar with a time-of-day alarm.
// Input stream: tuser = action (0 tick, 1 load); tdata carries the load
// fields, used only by a load beat. Every input beat makes one output beat
// holding the time after the update, the prescaler count and the alarm flag.
// Configuration: write i_cfg_data to register i_cfg_addr while i_cfg_we is
// high (0 ticks per second, 1..3 alarm second/minute/hour, 4 alarm enable);
// other indexes are ignored. Write only while the core is idle.
// The result is registered. Throughput: one beat per cycle while the receiver
// takes results; the whole carry chain and load clamp sit between the time
// registers and the output register.
// A two-entry output buffer (output register plus skid register) lets one
// more beat in while the receiver stalls; s_axis_tready drops only when both
// hold results. Results leave in order.
// Reset (synchronous, active low) sets 00:00:00, day 1, month 1, year 0,
// prescaler 0, rate 8 ticks per second, alarm off, and empties the buffer.
`include "calendar_clock_with_alarm_core_macros.svh"

module calendar_clock_with_alarm_core
    import ccwa_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // load_second, load_minute, load_hour, load_day, load_month, load_year
    input  wire  [InDataW-1:0]   s_axis_tdata,
    // action
    input  wire                  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // second, minute, hour, day, month, year, subsecond, alarm_match
    output logic [OutDataW-1:0]  m_axis_tdata,
    input  wire                  i_cfg_we,
    input  wire  [CfgAdrW-1:0]   i_cfg_addr,
    input  wire  [CfgW-1:0]      i_cfg_data
);

    logic [TickW-1:0] r_tps;
    logic [SecW-1:0]  r_al_sec;
    logic [MinW-1:0]  r_al_min;
    logic [HourW-1:0] r_al_hour;
    logic             r_al_en;

    logic [TickW-1:0] r_tick, n_tick;
    logic [SecW-1:0]  r_sec, n_sec;
    logic [MinW-1:0]  r_min, n_min;
    logic [HourW-1:0] r_hour, n_hour;
    logic [DayW-1:0]  r_day, n_day;
    logic [MonW-1:0]  r_month, n_month;
    logic [YearW-1:0] r_year, n_year;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    t_load           ld;
    logic            accept, pop;
    logic [TickW-1:0] rate;
    logic [TickW:0]   tick_next;
    logic            sec_step;
    logic [DayW-1:0] cur_len, ld_len;
    logic [SecW-1:0]  ld_sec;
    logic [MinW-1:0]  ld_min;
    logic [HourW-1:0] ld_hour;
    logic [MonW-1:0]  ld_month;
    logic [YearW-1:0] ld_year;

    assign ld     = t_load'(s_axis_tdata[LoadW-1:0]);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = r_out_valid && m_axis_tready;

    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW - ResultW){1'b0}}, r_out};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps     <= TpsReset;
            r_al_sec  <= '0;
            r_al_min  <= '0;
            r_al_hour <= '0;
            r_al_en   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CfgTicksPerSecond: r_tps     <= i_cfg_data;
                CfgAlarmSecond:    r_al_sec  <= i_cfg_data[SecW-1:0];
                CfgAlarmMinute:    r_al_min  <= i_cfg_data[MinW-1:0];
                CfgAlarmHour:      r_al_hour <= i_cfg_data[HourW-1:0];
                CfgAlarmEnable:    r_al_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Prescaler: a rate of zero acts as one
    assign rate      = (r_tps == '0) ? {{(TickW-1){1'b0}}, 1'b1} : r_tps;
    assign tick_next = {1'b0, r_tick} + {{TickW{1'b0}}, 1'b1};
    assign sec_step  = tick_next >= {1'b0, rate};
    assign cur_len   = f_month_length(r_month, r_year[1:0] == 2'b00);

    // Load clamp
    assign ld_sec   = (ld.second > LastSecond) ? LastSecond : ld.second;
    assign ld_min   = (ld.minute > LastMinute) ? LastMinute : ld.minute;
    assign ld_hour  = (ld.hour > LastHour) ? LastHour : ld.hour;
    assign ld_year  = (ld.year > LastYear) ? LastYear : ld.year;
    assign ld_month = (ld.month == '0) ? FirstMonth :
                      (ld.month > LastMonth) ? LastMonth : ld.month;
    assign ld_len   = f_month_length(ld_month, ld_year[1:0] == 2'b00);

    always_comb begin
        n_tick  = r_tick;
        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        unique case (t_action'(s_axis_tuser))
            ActLoad: begin
                n_tick  = '0;
                n_sec   = ld_sec;
                n_min   = ld_min;
                n_hour  = ld_hour;
                n_month = ld_month;
                n_year  = ld_year;
                n_day   = (ld.day == '0) ? FirstDay :
                          (ld.day > ld_len) ? ld_len : ld.day;
            end
            ActTick: begin
                if (!sec_step) begin
                    n_tick = tick_next[TickW-1:0];
                end else begin
                    n_tick = '0;
                    // carry second -> minute -> hour -> day -> month -> year
                    if (r_sec < LastSecond) begin
                        n_sec = r_sec + 1'b1;
                    end else begin
                        n_sec = '0;
                        if (r_min < LastMinute) begin
                            n_min = r_min + 1'b1;
                        end else begin
                            n_min = '0;
                            if (r_hour < LastHour) begin
                                n_hour = r_hour + 1'b1;
                            end else begin
                                n_hour = '0;
                                if (r_day < cur_len) begin
                                    n_day = r_day + 1'b1;
                                end else begin
                                    n_day = FirstDay;
                                    if (r_month < LastMonth) begin
                                        n_month = r_month + 1'b1;
                                    end else begin
                                        n_month = FirstMonth;
                                        n_year  = (r_year < LastYear) ?
                                                  r_year + 1'b1 : '0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase

        n_result.second      = n_sec;
        n_result.minute      = n_min;
        n_result.hour        = n_hour;
        n_result.day         = n_day;
        n_result.month       = n_month;
        n_result.year        = n_year;
        n_result.subsecond   = n_tick;
        n_result.alarm_match = r_al_en && (n_hour == r_al_hour) &&
                               (n_min == r_al_min) && (n_sec == r_al_sec);
    end

    // Time state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_sec   <= '0;
            r_min   <= '0;
            r_hour  <= '0;
            r_day   <= FirstDay;
            r_month <= FirstMonth;
            r_year  <= '0;
        end else if (accept) begin
            r_tick  <= n_tick;
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_hour  <= n_hour;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
        end
    end

    // Output buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // Output buffer payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || pop) begin
                if (r_skid_valid) begin
                    r_out  <= r_skid;
                    r_skid <= n_result;
                end else begin
                    r_out <= n_result;
                end
            end else begin
                r_skid <= n_result;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    `CCWA_ASSERT_IMPL(a_time_range, i_clk, i_rst_n, 1'b1,
        r_sec <= LastSecond && r_min <= LastMinute && r_hour <= LastHour)
    `CCWA_ASSERT_IMPL(a_date_range, i_clk, i_rst_n, 1'b1,
        r_day >= FirstDay && r_day <= cur_len && r_month >= FirstMonth &&
        r_month <= LastMonth && r_year <= LastYear)
    `CCWA_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `CCWA_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        accept && r_out_valid && !m_axis_tready, r_skid_valid)

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ccwa_pkg::*;

    localparam int LongHold = 300;
    localparam int NumSettings = 6;
    localparam int RunLength = 200;
    localparam logic [CfgAdrW-1:0] CfgSpareLo = 3'd5;
    localparam logic [CfgAdrW-1:0] CfgSpareHi = 3'd7;

    typedef struct {
        t_action    act;
        t_load      ld;
        bit         wait_drain;
    } t_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    // load_second, load_minute, load_hour, load_day, load_month, load_year
    logic [InDataW-1:0]  s_axis_tdata = '0;
    // action
    logic                s_axis_tuser = 1'b0;
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // second, minute, hour, day, month, year, subsecond, alarm_match
    wire [OutDataW-1:0]  m_axis_tdata;
    logic                cfg_we = 1'b0;
    logic [CfgAdrW-1:0]  cfg_addr = '0;
    logic [CfgW-1:0]     cfg_data = '0;

    calendar_clock_with_alarm_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data)
    );

    // Register copies and calendar state of the predictor.
    int tps_cfg = 8;
    int alm_sec = 0;
    int alm_min = 0;
    int alm_hour = 0;
    int alm_en = 0;
    int cal_tick = 0;
    int cal_sec = 0;
    int cal_min = 0;
    int cal_hour = 0;
    int cal_day = 1;
    int cal_month = 1;
    int cal_year = 0;

    t_beat   pending_beats[$];
    t_result readings_due[$];
    t_beat   cur_beat;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int mismatches = 0;
    int readings_checked = 0;
    int alarm_hits = 0;
    int ticks_in = 0;
    int loads_in = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("calendar_clock_with_alarm_core regression: fail");
        $finish;
    end

    function automatic int days_in_month(input int mon, input int yr);
        if (mon == 2)
            return (yr % 4 == 0) ? 29 : 28;
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
            return 30;
        return 31;
    endfunction

    // Apply one beat to the calendar and return the reading it produces.
    function automatic t_result clock_after_beat(input t_action act, input t_load ld);
        t_result r;
        int rate;
        int s, mi, h, d, mo, y;
        if (act == ActTick) begin
            rate = (tps_cfg == 0) ? 1 : tps_cfg;
            if (cal_tick + 1 >= rate) begin
                cal_tick = 0;
                cal_sec++;
                if (cal_sec == 60) begin
                    cal_sec = 0;
                    cal_min++;
                    if (cal_min == 60) begin
                        cal_min = 0;
                        cal_hour++;
                        if (cal_hour == 24) begin
                            cal_hour = 0;
                            cal_day++;
                            if (cal_day > days_in_month(cal_month, cal_year)) begin
                                cal_day = 1;
                                cal_month++;
                                if (cal_month > 12) begin
                                    cal_month = 1;
                                    cal_year = (cal_year == 99) ? 0 : cal_year + 1;
                                end
                            end
                        end
                    end
                end
            end else begin
                cal_tick++;
            end
        end else begin
            s = int'(ld.second);
            mi = int'(ld.minute);
            h = int'(ld.hour);
            d = int'(ld.day);
            mo = int'(ld.month);
            y = int'(ld.year);
            if (s > 59) s = 59;
            if (mi > 59) mi = 59;
            if (h > 23) h = 23;
            if (y > 99) y = 99;
            if (mo < 1) mo = 1;
            if (mo > 12) mo = 12;
            if (d < 1) d = 1;
            if (d > days_in_month(mo, y)) d = days_in_month(mo, y);
            cal_sec = s;
            cal_min = mi;
            cal_hour = h;
            cal_day = d;
            cal_month = mo;
            cal_year = y;
            cal_tick = 0;
        end
        r.second = SecW'(cal_sec);
        r.minute = MinW'(cal_min);
        r.hour = HourW'(cal_hour);
        r.day = DayW'(cal_day);
        r.month = MonW'(cal_month);
        r.year = YearW'(cal_year);
        r.subsecond = TickW'(cal_tick);
        r.alarm_match = (alm_en != 0 && cal_hour == alm_hour && cal_min == alm_min &&
                         cal_sec == alm_sec);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [CfgAdrW-1:0] idx, input logic [CfgW-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CfgTicksPerSecond: tps_cfg = int'(val);
            CfgAlarmSecond:    alm_sec = int'(val[SecW-1:0]);
            CfgAlarmMinute:    alm_min = int'(val[MinW-1:0]);
            CfgAlarmHour:      alm_hour = int'(val[HourW-1:0]);
            CfgAlarmEnable:    alm_en = int'(val[0]);
            default: ;
        endcase
    endtask

    task automatic push_load(input int s, input int mi, input int h, input int d,
                             input int mo, input int y);
        t_beat b;
        b.act = ActLoad;
        b.wait_drain = 1'b0;
        b.ld.second = SecW'(s);
        b.ld.minute = MinW'(mi);
        b.ld.hour = HourW'(h);
        b.ld.day = DayW'(d);
        b.ld.month = MonW'(mo);
        b.ld.year = YearW'(y);
        pending_beats.push_back(b);
    endtask

    task automatic push_ticks(input int count);
        t_beat b;
        logic [LoadW-1:0] raw;
        for (int n = 0; n < count; n++) begin
            raw = LoadW'({$urandom, $urandom});
            b.act = ActTick;
            b.ld = raw;
            b.wait_drain = 1'b0;
            pending_beats.push_back(b);
        end
    endtask

    // Loads aimed at rollovers or just ahead of the alarm, plus plain noise.
    function automatic t_load random_load();
        logic [LoadW-1:0] raw;
        t_load ld;
        int lag;
        raw = LoadW'({$urandom, $urandom});
        ld = raw;
        case ($urandom_range(2))
            0: ;
            1: begin
                ld.second = SecW'($urandom_range(57, 63));
                ld.minute = MinW'($urandom_range(59, 63));
                ld.hour = HourW'($urandom_range(23, 31));
                ld.day = DayW'($urandom_range(27, 31));
                if ($urandom_range(1) == 1)
                    ld.year = YearW'($urandom_range(95, 127));
            end
            default: begin
                if (alm_sec <= 59 && alm_min <= 59 && alm_hour <= 23) begin
                    lag = $urandom_range(3);
                    ld.hour = HourW'(alm_hour);
                    ld.minute = MinW'(alm_min);
                    ld.second = SecW'((alm_sec >= lag) ? alm_sec - lag : 0);
                end
            end
        endcase
        return ld;
    endfunction

    task automatic queue_random_run(input int count);
        t_beat b;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 12) begin
                b.act = ActLoad;
                b.ld = random_load();
                b.wait_drain = ($urandom_range(99) < 2);
                pending_beats.push_back(b);
            end else begin
                push_ticks(1);
                if ($urandom_range(99) < 2)
                    pending_beats[$].wait_drain = 1'b1;
            end
        end
    endtask

    // Let the core go idle: all beats sent, all readings back, output register settled.
    task automatic settle();
        while (pending_beats.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: predict on each accepted beat, then offer the next one.
    always @(posedge i_clk) begin
        t_beat nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                readings_due.push_back(clock_after_beat(cur_beat.act, cur_beat.ld));
                if (cur_beat.act == ActTick)
                    ticks_in++;
                else
                    loads_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() != 0 &&
                    !(pending_beats[0].wait_drain && readings_due.size() != 0) &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_beats.pop_front();
                    cur_beat = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(InDataW - LoadW){1'b0}}, nxt.ld};
                    s_axis_tuser <= nxt.act;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold when asked for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_seen = hold_toggle;
        end else if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = LongHold;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each output beat against the oldest reading due.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[ResultW-1:0];
            if (readings_due.size() == 0) begin
                $error("output beat with no reading due");
                mismatches++;
            end else begin
                want = readings_due.pop_front();
                compare_field("second", int'(want.second), int'(got.second));
                compare_field("minute", int'(want.minute), int'(got.minute));
                compare_field("hour", int'(want.hour), int'(got.hour));
                compare_field("day", int'(want.day), int'(got.day));
                compare_field("month", int'(want.month), int'(got.month));
                compare_field("year", int'(want.year), int'(got.year));
                compare_field("subsecond", int'(want.subsecond), int'(got.subsecond));
                compare_field("alarm_match", int'(want.alarm_match),
                              int'(got.alarm_match));
                readings_checked++;
                if (got.alarm_match)
                    alarm_hits++;
            end
        end
    end

    initial begin
        int set_rate [NumSettings] = '{1, 255, 0, 2, 3, 1};
        int set_asec [NumSettings] = '{59, 0, 63, 30, 17, 0};
        int set_amin [NumSettings] = '{59, 0, 63, 0, 45, 0};
        int set_ahour [NumSettings] = '{23, 0, 31, 12, 6, 0};
        int set_aen [NumSettings] = '{1, 0, 1, 1, 1, 1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sender_idle_pct = 28;
        recv_stall_pct = 58;

        // Reset rate: year wrap from the saturated load, then load clamps.
        push_ticks(1);
        push_load(63, 63, 31, 31, 15, 127);
        push_ticks(8);
        push_load(0, 0, 0, 0, 0, 0);
        push_load(10, 20, 5, 31, 2, 1);
        push_load(10, 20, 5, 31, 2, 0);
        push_load(59, 59, 23, 31, 4, 4);
        push_load(59, 59, 23, 28, 2, 3);
        settle();

        // Rate zero behaves as one; alarm at 00:00:01.
        write_reg(CfgTicksPerSecond, 8'd0);
        write_reg(CfgAlarmSecond, 8'd1);
        write_reg(CfgAlarmEnable, 8'd1);
        push_ticks(2);
        push_load(59, 59, 23, 30, 4, 4);
        push_ticks(1);
        settle();

        // Build up a prescaler count, then drop the rate below it.
        write_reg(CfgTicksPerSecond, 8'd255);
        push_load(0, 0, 0, 1, 1, 0);
        push_ticks(4);
        settle();
        write_reg(CfgTicksPerSecond, 8'd3);
        for (int a = CfgSpareLo; a <= CfgSpareHi; a++)
            write_reg(CfgAdrW'(a), 8'hFF);
        push_ticks(1);

        for (int ph = 0; ph < NumSettings; ph++) begin
            settle();
            if (ph == 2) begin
                sender_idle_pct = 58;
                recv_stall_pct = 28;
            end else if (ph == 4) begin
                sender_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (ph == 3) begin
                set_asec[ph] = $urandom_range(59);
                set_amin[ph] = $urandom_range(59);
                set_ahour[ph] = $urandom_range(23);
            end
            write_reg(CfgTicksPerSecond, CfgW'(set_rate[ph]));
            write_reg(CfgAlarmSecond, CfgW'(set_asec[ph]));
            write_reg(CfgAlarmMinute, CfgW'(set_amin[ph]));
            write_reg(CfgAlarmHour, CfgW'(set_ahour[ph]));
            write_reg(CfgAlarmEnable, CfgW'(set_aen[ph]));
            queue_random_run(RunLength);
            // Stall the output while the sender keeps pushing.
            if (ph == 4)
                hold_toggle <= ~hold_toggle;
        end
        settle();

        $display("covered %0d beats (%0d ticks, %0d loads) over %0d rate/alarm settings",
                 ticks_in + loads_in, ticks_in, loads_in, NumSettings + 3);
        $display("checked %0d readings, %0d of them with the alarm raised",
                 readings_checked, alarm_hits);
        if (mismatches == 0)
            $display("calendar_clock_with_alarm_core regression: pass");
        else
            $display("calendar_clock_with_alarm_core regression: fail");
        $finish;
    end

endmodule
